@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the advect/deposit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define PSAD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true outside reset
`define PSAD_NEVER(lbl, clk, rst_n, expr, msg) \
  `PSAD_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

@@ sv/psad_pkg.sv @@
// ----------------------------------------------------------------------------
// psad_pkg
// Types and constants of the phase-space advect/deposit block.
// ----------------------------------------------------------------------------
package psad_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 8;
  localparam int GRID_V     = 256;
  localparam int GRID_X     = 256;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int VAL_W      = 32;
  localparam int ACC_W      = 24;
  localparam int SCALE_W    = 24;
  localparam int VOFF_W     = 13;

  localparam int PROD1_W    = ACC_W + SCALE_W + 1;
  localparam int DV_W       = PROD1_W - FRAC_BITS;
  localparam int U_W        = DV_W + 2;
  localparam int W_W        = VOFF_W + FRAC_BITS + 1;
  localparam int PROD2_W    = W_W + SCALE_W + 1;
  localparam int DRIFT_W    = PROD2_W - FRAC_BITS;
  localparam int XP_W       = DRIFT_W + 1;

  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  typedef enum logic [1:0] {
    REG_ACCEL_SCALE = 2'd0,
    REG_DRIFT_SCALE = 2'd1,
    REG_VEL_OFFSET  = 2'd2
  } reg_idx_t;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MUL1  = 8'b0000_0100,
    S_KICK  = 8'b0000_1000,
    S_MUL2  = 8'b0001_0000,
    S_DRIFT = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_WB    = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic clr;
    logic capture;
    logic mul1;
    logic kick;
    logic mul2;
    logic drift;
    logic mem_rd;
    logic wb;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic drop;
    logic out_full;
  } dp_sts_t;

endpackage

@@ sv/psad_regs.sv @@
// ----------------------------------------------------------------------------
// psad_regs
// APB-style configuration registers: accel scale, drift scale, velocity offset.
// ----------------------------------------------------------------------------
module psad_regs import psad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready,
  output logic [SCALE_W-1:0]       accel_scale,
  output logic [SCALE_W-1:0]       drift_scale,
  output logic signed [VOFF_W-1:0] vel_offset
);

  logic [SCALE_W-1:0] accel_scale_r;
  logic [SCALE_W-1:0] drift_scale_r;
  logic [VOFF_W-1:0]  vel_offset_r;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_scale_r <= SCALE_W'(24'h333333);
      drift_scale_r <= SCALE_W'(24'h003333);
      vel_offset_r  <= VOFF_W'(13'h1F80);
    end else if (wr_en) begin
      case (idx)
        REG_ACCEL_SCALE: accel_scale_r <= pwdata[SCALE_W-1:0];
        REG_DRIFT_SCALE: drift_scale_r <= pwdata[SCALE_W-1:0];
        REG_VEL_OFFSET:  vel_offset_r  <= pwdata[VOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACCEL_SCALE: prdata = CFG_DW'(accel_scale_r);
      REG_DRIFT_SCALE: prdata = CFG_DW'(drift_scale_r);
      REG_VEL_OFFSET:  prdata = CFG_DW'($signed(vel_offset_r));
      default:         prdata = '0;
    endcase
  end

  assign accel_scale = accel_scale_r;
  assign drift_scale = drift_scale_r;
  assign vel_offset  = $signed(vel_offset_r);

endmodule

@@ sv/psad_ctrl.sv @@
// ----------------------------------------------------------------------------
// psad_ctrl
// Sequencer: grid clear after reset, then one item at a time through the
// datapath steps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psad_ctrl import psad_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_cmd,
  output logic    in_tready,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready     = 1'b1;
        cmd_o.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = in_cmd ? S_RD : S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_nxt  = S_KICK;
      end
      S_KICK: begin
        cmd_o.kick = 1'b1;
        state_nxt  = sts_i.drop ? S_WB : S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_nxt  = S_DRIFT;
      end
      S_DRIFT: begin
        cmd_o.drift = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_nxt    = S_WB;
      end
      S_WB: begin
        if (!sts_i.out_full) begin
          cmd_o.wb  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `PSAD_NEVER(a_wb_into_full, clk, rst_n, cmd_o.wb && sts_i.out_full, "write-back into full output register")
  `PSAD_ASSERT(a_read_goes_to_rd, clk, rst_n, (in_tvalid && in_tready && in_cmd) |=> (state_r == S_RD), "read beat did not go straight to memory read")

endmodule

@@ sv/psad_dp.sv @@
// ----------------------------------------------------------------------------
// psad_dp
// Datapath: kick and drift arithmetic, accumulation grid memory with
// saturating read-modify-write, clear sweep and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psad_dp import psad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd_i,
  output dp_sts_t                  sts_o,
  input  logic                     in_cmd,
  input  logic [IDX_W-1:0]         in_v,
  input  logic [IDX_W-1:0]         in_x,
  input  logic [VAL_W-1:0]         in_val,
  input  logic signed [ACC_W-1:0]  in_acc,
  input  logic [SCALE_W-1:0]       accel_scale,
  input  logic [SCALE_W-1:0]       drift_scale,
  input  logic signed [VOFF_W-1:0] vel_offset,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VAL_W-1:0]         out_read_value,
  output logic [IDX_W-1:0]         out_dest_v,
  output logic [IDX_W-1:0]         out_dest_x,
  output logic                     out_dropped,
  output logic                     out_saturated
);

  localparam logic [FRAC_BITS-1:0]  HALF   = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS-1:0]  ZERO_F = '0;
  localparam logic signed [U_W-1:0] U_MIN  = -U_W'(2 ** FRAC_BITS);
  localparam logic signed [U_W-1:0] U_LIM  = U_W'(GRID_V) << FRAC_BITS;

  logic [VAL_W-1:0] mem [2 ** ADDR_W];

  logic                      cmd_r;
  logic [IDX_W-1:0]          vi_r;
  logic [IDX_W-1:0]          xi_r;
  logic [VAL_W-1:0]          val_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [PROD1_W-1:0] prod1_r;
  logic [IDX_W-1:0]          iv_r;
  logic                      drop_r;
  logic signed [W_W-1:0]     w_r;
  logic signed [PROD2_W-1:0] prod2_r;
  logic [ADDR_W-1:0]         addr_r;
  logic [VAL_W-1:0]          rdata_r;
  logic [ADDR_W-1:0]         clr_addr_r;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [VAL_W-1:0]          out_rv_r;
  logic [IDX_W-1:0]          out_dv_r;
  logic [IDX_W-1:0]          out_dx_r;
  logic                      out_drop_r;
  logic                      out_sat_r;

  logic signed [DV_W-1:0]    dv;
  logic signed [U_W-1:0]     u;
  logic                      keep;
  logic [IDX_W-1:0]          iv;
  logic signed [W_W-1:0]     w;
  logic signed [DRIFT_W-1:0] dx;
  logic signed [XP_W-1:0]    xp;
  logic [IDX_W-1:0]          jx;
  logic [VAL_W:0]            sum;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [VAL_W-1:0]          mem_wdata;

  // kick: new velocity in grid cells, truncated row, off-grid test
  assign dv   = $signed(prod1_r[PROD1_W-1:FRAC_BITS]);
  assign u    = $signed({{(U_W - IDX_W - FRAC_BITS){1'b0}}, vi_r, HALF}) + U_W'(dv);
  assign keep = (u > U_MIN) && (u < U_LIM);
  assign iv   = u[U_W-1] ? '0 : u[FRAC_BITS+IDX_W-1:FRAC_BITS];
  assign w    = W_W'(u) + W_W'($signed({vel_offset, ZERO_F}));

  // drift: position, truncated toward zero, periodic wrap by low bits
  assign dx = $signed(prod2_r[PROD2_W-1:FRAC_BITS]);
  assign xp = XP_W'(dx) + $signed({{(XP_W - IDX_W - FRAC_BITS){1'b0}}, xi_r, HALF});
  assign jx = xp[FRAC_BITS+IDX_W-1:FRAC_BITS]
            + IDX_W'(xp[XP_W-1] & (|xp[FRAC_BITS-1:0]));

  assign sum = {1'b0, rdata_r} + {1'b0, val_r};

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r <= in_cmd;
      vi_r  <= in_v;
      xi_r  <= in_x;
      val_r <= in_val;
      acc_r <= in_acc;
    end
    if (cmd_i.mul1) begin
      prod1_r <= PROD1_W'(acc_r) * PROD1_W'($signed({1'b0, accel_scale}));
    end
    if (cmd_i.kick) begin
      iv_r <= iv;
      w_r  <= w;
    end
    if (cmd_i.mul2) begin
      prod2_r <= PROD2_W'(w_r) * PROD2_W'($signed({1'b0, drift_scale}));
    end
    if (cmd_i.capture) begin
      addr_r <= {in_v, in_x};
    end else if (cmd_i.drift) begin
      addr_r <= {iv_r, jx};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_r <= 1'b0;
    end else if (cmd_i.capture) begin
      drop_r <= 1'b0;
    end else if (cmd_i.kick) begin
      drop_r <= ~keep;
    end
  end

  // grid memory: one write port, one registered read port
  assign mem_we    = cmd_i.clr | (cmd_i.wb & ~drop_r);
  assign mem_waddr = cmd_i.clr ? clr_addr_r : addr_r;
  assign mem_wdata = (cmd_i.clr | cmd_r) ? '0 : (sum[VAL_W] ? '1 : sum[VAL_W-1:0]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.mem_rd) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  // output register
  assign out_valid_nxt = cmd_i.wb | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.wb) begin
      out_rv_r   <= cmd_r ? rdata_r : '0;
      out_dv_r   <= (cmd_r | drop_r) ? '0 : addr_r[ADDR_W-1:IDX_W];
      out_dx_r   <= (cmd_r | drop_r) ? '0 : addr_r[IDX_W-1:0];
      out_drop_r <= ~cmd_r & drop_r;
      out_sat_r  <= ~cmd_r & ~drop_r & sum[VAL_W];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_dest_v     = out_dv_r;
  assign out_dest_x     = out_dx_r;
  assign out_dropped    = out_drop_r;
  assign out_saturated  = out_sat_r;

  assign sts_o.clear_last = &clr_addr_r;
  assign sts_o.drop       = ~keep;
  assign sts_o.out_full   = out_valid_r & ~out_ready;

  `PSAD_NEVER(a_clear_vs_wb, clk, rst_n, cmd_i.clr && cmd_i.wb, "write-back during grid clear")
  `PSAD_ASSERT(a_wb_loads_out, clk, rst_n, cmd_i.wb |=> out_valid_r, "write-back did not load output register")
  `PSAD_ASSERT(a_sat_not_drop, clk, rst_n, (out_valid_r && out_sat_r) |-> !out_drop_r, "saturated flag on a dropped cell")

endmodule

@@ sv/phase_space_advect_deposit_top.sv @@
// ----------------------------------------------------------------------------
// phase_space_advect_deposit_top
// Vlasov phase-space push and saturating deposit into a 256x256 grid.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata: v_index,x_index,cell_value,accel
//  out_    | out | tvalid/tready      | tdata: read_value,dest_v,dest_x; tuser flags
//  cfg_    | in  | psel/penable/pready| 3 registers at 0x0, 0x4, 0x8
//
//  Advect beat steps from accept to next ready: MUL1, KICK, MUL2, DRIFT, RD, WB
//  (two multiplies, memory RMW). Dropped advect: MUL1, KICK, WB. Read beat: RD, WB.
//  After reset the grid is cleared, one entry per cycle, with in_tready low.
//  The output register frees the input side; a beat stalls only in write-back
//  while the previous result is still untaken.
// ----------------------------------------------------------------------------
module phase_space_advect_deposit_top import psad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [71:0]       in_tdata,   // v_index, x_index, cell_value, accel
  input  logic              in_tuser,   // cmd
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // read_value, dest_v, dest_x
  output logic [1:0]        out_tuser,  // dropped, saturated
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [SCALE_W-1:0]       accel_scale;
  logic [SCALE_W-1:0]       drift_scale;
  logic signed [VOFF_W-1:0] vel_offset;
  dp_cmd_t                  dp_cmd;
  dp_sts_t                  dp_sts;
  logic [VAL_W-1:0]         read_value;
  logic [IDX_W-1:0]         dest_v;
  logic [IDX_W-1:0]         dest_x;
  logic                     dropped;
  logic                     saturated;

  psad_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .accel_scale (accel_scale),
    .drift_scale (drift_scale),
    .vel_offset  (vel_offset)
  );

  psad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tuser),
    .in_tready (in_tready),
    .cmd_o     (dp_cmd),
    .sts_i     (dp_sts)
  );

  psad_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .in_cmd         (in_tuser),
    .in_v           (in_tdata[7:0]),
    .in_x           (in_tdata[15:8]),
    .in_val         (in_tdata[47:16]),
    .in_acc         ($signed(in_tdata[71:48])),
    .accel_scale    (accel_scale),
    .drift_scale    (drift_scale),
    .vel_offset     (vel_offset),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_read_value (read_value),
    .out_dest_v     (dest_v),
    .out_dest_x     (dest_x),
    .out_dropped    (dropped),
    .out_saturated  (saturated)
  );

  assign out_tdata = {dest_x, dest_v, read_value};
  assign out_tuser = {saturated, dropped};

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the phase-space advect/deposit block. Items go in on
// the in_ stream, results are taken from the out_ stream and compared with a
// built-in predictor that does the kick, drift, periodic wrap and saturating
// deposit on its own copy of the grid and registers. Both sides idle at
// random; one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top import psad_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit           CMD_ADVECT   = 1'b0;
  localparam bit           CMD_READ     = 1'b1;
  localparam logic [1:0]   REG_UNLISTED = 2'd3;
  localparam longint       ONE          = longint'(1) << FRAC_BITS;
  localparam longint       HALF         = longint'(1) << (FRAC_BITS - 1);
  localparam int           DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [31:0] read_value;
    logic [7:0]  dest_v;
    logic [7:0]  dest_x;
    logic        dropped;
    logic        saturated;
  } deposit_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [71:0]       in_tdata;   // v_index, x_index, cell_value, accel
  logic              in_tuser;   // cmd
  logic              out_tvalid;
  logic              out_tready;
  logic [47:0]       out_tdata;  // read_value, dest_v, dest_x
  logic [1:0]        out_tuser;  // dropped, saturated
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // predictor state
  logic [31:0]        grid [GRID_V*GRID_X];
  logic [23:0]        scale_accel;
  logic [23:0]        scale_drift;
  logic signed [12:0] offset_vel;
  deposit_t           due_results [$];
  logic [15:0]        recent_dest [$];

  bit quiet_gaps;
  int sink_hold;
  int fail_count;
  int n_beats, n_advects, n_drops, n_reads, n_sats, n_wraps, n_settings;

  phase_space_advect_deposit_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic longint to_cell(longint s);
    return (s >= 0) ? (s >>> FRAC_BITS) : -((-s) >>> FRAC_BITS);
  endfunction

  function automatic deposit_t push_and_deposit(bit cmd, logic [7:0] vi, logic [7:0] xi,
                                                logic [31:0] val, logic signed [23:0] acc);
    deposit_t         r;
    longint           vs, xs, a, ak, dk, vo, u, iv, w, xc, jx;
    longint unsigned  sum;
    int               idx;
    r  = '0;
    vs = longint'(vi);
    xs = longint'(xi);
    a  = longint'(acc);
    ak = longint'(scale_accel);
    dk = longint'(scale_drift);
    vo = longint'(offset_vel);
    if (cmd == CMD_READ) begin
      idx = int'({vi, xi});
      r.read_value = grid[idx];
      grid[idx] = '0;
      n_reads++;
      return r;
    end
    n_advects++;
    u  = vs * ONE + HALF + ((a * ak) >>> FRAC_BITS);
    iv = to_cell(u);
    if (iv < 0 || iv >= GRID_V) begin
      r.dropped = 1'b1;
      n_drops++;
      return r;
    end
    w  = vo * ONE + u;
    xc = to_cell(xs * ONE + HALF + ((dk * w) >>> FRAC_BITS));
    if (xc < 0 || xc >= GRID_X) n_wraps++;
    jx = xc % GRID_X;
    if (jx < 0) jx += GRID_X;
    idx = int'(iv * GRID_X + jx);
    sum = 64'(grid[idx]);
    sum = sum + 64'(val);
    if (sum > 64'hFFFF_FFFF) begin
      sum = 64'hFFFF_FFFF;
      r.saturated = 1'b1;
      n_sats++;
    end
    grid[idx] = sum[31:0];
    r.dest_v = iv[7:0];
    r.dest_x = jx[7:0];
    recent_dest.push_back(idx[15:0]);
    if (recent_dest.size() > 64) void'(recent_dest.pop_front());
    return r;
  endfunction

  // ---- result checking
  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    deposit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      if (due_results.size() == 0) begin
        $error("result beat with nothing outstanding: tdata 0x%0h tuser 0x%0h",
               out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("read_value", want.read_value, out_tdata[31:0]);
        check_field("dest_v",     32'(want.dest_v),    32'(out_tdata[39:32]));
        check_field("dest_x",     32'(want.dest_x),    32'(out_tdata[47:40]));
        check_field("dropped",    32'(want.dropped),   32'(out_tuser[0]));
        check_field("saturated",  32'(want.saturated), 32'(out_tuser[1]));
      end
    end
  end

  // ---- result sink with random stalls and requested hold-offs
  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (sink_hold != 0) begin
        out_tready = 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      gap = quiet_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // ---- stimulus helpers
  task automatic send_item(bit cmd, logic [7:0] v, logic [7:0] x, logic [31:0] val,
                           logic signed [23:0] acc);
    int gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {acc, val, x, v};
    do @(posedge clk); while (!in_tready);
    due_results.push_back(push_and_deposit(cmd, v, x, val, acc));
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    case (idx)
      REG_ACCEL_SCALE: scale_accel = data[23:0];
      REG_DRIFT_SCALE: scale_drift = data[23:0];
      REG_VEL_OFFSET:  offset_vel  = data[12:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [23:0] a_scale, logic [23:0] d_scale,
                                logic signed [12:0] v_off);
    settle();
    write_reg(REG_ACCEL_SCALE, {8'd0, a_scale});
    write_reg(REG_DRIFT_SCALE, {8'd0, d_scale});
    write_reg(REG_VEL_OFFSET, {{19{v_off[12]}}, v_off});
    n_settings++;
  endtask

  // mostly advects with log-spread accel, reads aimed at recent deposits
  task automatic run_random(int count);
    int                 pick, k, slot;
    logic [7:0]         v, x;
    logic [31:0]        val, mag;
    logic signed [23:0] acc;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      v    = 8'($urandom_range(0, 255));
      x    = 8'($urandom_range(0, 255));
      val  = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 1023)) : $urandom();
      if ($urandom_range(0, 9) == 0) begin
        acc = 24'($urandom());
      end else begin
        k   = $urandom_range(0, 23);
        mag = $urandom_range(0, (1 << k) - 1);
        acc = $urandom_range(0, 1) ? -mag[23:0] : mag[23:0];
      end
      if (pick < 35) begin
        if (recent_dest.size() != 0 && $urandom_range(0, 3) != 0) begin
          slot   = $urandom_range(0, recent_dest.size() - 1);
          {v, x} = recent_dest[slot];
        end
        send_item(CMD_READ, v, x, val, acc);
      end else begin
        send_item(CMD_ADVECT, v, x, val, acc);
      end
    end
  endtask

  // ---- tests
  task automatic test_directed_edges();
    logic [7:0] v, x;
    send_item(CMD_ADVECT, 8'd0, 8'd0, 32'd0, 24'sd0);
    send_item(CMD_ADVECT, 8'd255, 8'd255, 32'hFFFF_FFFF, 24'sh7F_FFFF);
    send_item(CMD_ADVECT, 8'd128, 8'd17, 32'h1234_5678, 24'sh80_0000);
    send_item(CMD_ADVECT, 8'd0, 8'd40, 32'h0000_0100, -24'sd1000);
    send_item(CMD_ADVECT, 8'd10, 8'd10, 32'hFFFF_FFF0, 24'sd0);
    send_item(CMD_ADVECT, 8'd10, 8'd10, 32'hFFFF_FFF0, 24'sd0);
    {v, x} = recent_dest[$];
    send_item(CMD_READ, v, x, $urandom(), 24'($urandom()));
    send_item(CMD_READ, v, x, $urandom(), 24'($urandom()));
    send_item(CMD_READ, 8'd255, 8'd255, 32'hFFFF_FFFF, 24'sh7F_FFFF);
    send_item(CMD_READ, 8'd0, 8'd0, 32'd0, 24'sd0);
    // unity kick: accel maps straight onto the velocity change
    apply_settings(24'h01_0000, scale_drift, offset_vel);
    send_item(CMD_ADVECT, 8'd0, 8'd5, 32'd7, -24'sd32769);
    send_item(CMD_ADVECT, 8'd0, 8'd5, 32'd7, -24'sd98303);
    send_item(CMD_ADVECT, 8'd0, 8'd5, 32'd7, -24'sd98304);
    send_item(CMD_ADVECT, 8'd255, 8'd250, 32'd9, 24'sd32767);
    send_item(CMD_ADVECT, 8'd255, 8'd250, 32'd9, 24'sd32768);
    send_item(CMD_ADVECT, 8'd200, 8'd3, 32'd1, 24'sd0);
    {v, x} = recent_dest[$];
    send_item(CMD_READ, v, x, 32'd0, 24'sd0);
  endtask

  task automatic test_unlisted_register();
    settle();
    write_reg(REG_UNLISTED, 32'hFFFF_FFFF);
    run_random(20);
  endtask

  task automatic test_register_sweep();
    apply_settings(24'h00_0000, 24'h00_0000, 13'sd0);
    run_random(100);
    apply_settings(24'hFF_FFFF, 24'hFF_FFFF, -13'sd4096);
    run_random(100);
    apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 13'sd0);
    run_random(100);
    apply_settings(24'h01_0000, 24'h01_0000, -13'sd128);
    run_random(100);
    repeat (3) begin
      apply_settings(24'($urandom_range(0, 24'hFF_FFFF)),
                     24'($urandom_range(0, 24'h0F_FFFF)),
                     13'(-$urandom_range(0, 4096)));
      run_random(100);
    end
    apply_settings(24'd3355443, 24'd13107, -13'sd128);
  endtask

  task automatic test_random_traffic();
    repeat (6) begin
      quiet_gaps = ($urandom_range(0, 3) == 0);
      run_random(55);
    end
    quiet_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    quiet_gaps = 1'b1;
    sink_hold  = 300;
    run_random(30);
    quiet_gaps = 1'b0;
  endtask

  initial begin : main
    foreach (grid[i]) grid[i] = '0;
    scale_accel = 24'd3355443;
    scale_drift = 24'd13107;
    offset_vel  = -13'sd128;
    quiet_gaps  = 1'b0;
    sink_hold   = 0;
    fail_count  = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_unlisted_register();
    test_register_sweep();
    test_random_traffic();
    test_output_backpressure();

    settle();
    $display("Checked %0d beats: %0d advects (%0d dropped, %0d wrapped, %0d saturated),",
             n_beats, n_advects, n_drops, n_wraps, n_sats);
    $display("%0d read-and-clear beats, %0d register settings plus an unlisted write.",
             n_reads, n_settings);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
